FILE: rtl/nearest_free_slot_allocator_top_defines.svh
// Assertion macros for the slot allocator.
`ifndef NEAREST_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define NEAREST_FREE_SLOT_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NFSA_ASSERT_IMP(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("nfsa assertion failed");
`define NFSA_ASSERT_NXT(lbl, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("nfsa assertion failed");
`else
`define NFSA_ASSERT_IMP(lbl, cond, expr)
`define NFSA_ASSERT_NXT(lbl, cond, expr)
`endif

`endif

FILE: rtl/nfsa_pkg.sv
package nfsa_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int ACTIVE_W      = 7;
    localparam int PREF_W        = 6;
    localparam int SLOT_W        = 6;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

    localparam logic ACT_CLAIM = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SEARCH,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic {
        SIDE_LEFT,
        SIDE_RIGHT
    } side_t;

    typedef struct packed {
        logic              action;
        logic [PREF_W-1:0] preferred;
    } req_item_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
    } rsp_item_t;

endpackage

FILE: rtl/nearest_free_slot_allocator_top.sv
// A claim searches the n active slots (the active slot count capped at MAX_SLOTS) around
// its preferred slot, reading at most one map slot per cycle through its single read port.
// A clear frees every map entry in turn, one map entry per cycle.
// One transaction is in progress at a time; the next is taken the cycle after its result
// is loaded, which waits while the previous result is stalled. After reset a clearing pass
// over all MAX_SLOTS entries runs; config writes are taken throughout and active_slots resets to 64.
`include "nearest_free_slot_allocator_top_defines.svh"

module nearest_free_slot_allocator_top
    import nfsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_item_t           req_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_item_t           rsp_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ACTIVE_W-1:0] cfg_data
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int SW = NW + 1;
    localparam int CW = (NW > ACTIVE_W) ? NW : ACTIVE_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

    state_t              state_reg, state_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [IW-1:0]       pref_reg, pref_next;
    logic [NW-1:0]       d_reg, d_next;
    side_t               side_reg, side_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       pend_addr_reg, pend_addr_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic                res_granted_reg, res_granted_next;
    logic [IW-1:0]       res_addr_reg, res_addr_next;
    logic                out_valid_reg, out_valid_next;
    rsp_item_t           out_data_reg, out_data_next;
    logic [ACTIVE_W-1:0] active_reg;
    logic                rd_data_reg;

    logic                mem [MAX_SLOTS];
    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic                mem_wdata;
    logic                mem_re;
    logic [IW-1:0]       mem_raddr;

    logic                req_accept;
    logic [CW-1:0]       act_w;
    logic [CW-1:0]       max_w;
    logic [CW-1:0]       n_c;
    logic [CW-1:0]       pref_c;
    logic [CW-1:0]       clamp_c;
    logic [SW-1:0]       d_w;
    logic [SW-1:0]       pref_w;
    logic [SW-1:0]       n_w;
    logic                left_ok;
    logic                right_ok;
    logic [IW-1:0]       left_addr;
    logic [IW-1:0]       right_addr;
    logic                map_hit;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = out_valid_reg;
    assign rsp_data   = out_data_reg;

    assign act_w   = CW'(active_reg);
    assign max_w   = CW'(MAX_SLOTS);
    assign n_c     = (act_w > max_w) ? max_w : act_w;
    assign pref_c  = CW'(req_data.preferred);
    assign clamp_c = (pref_c >= n_c) ? (n_c - CW'(1)) : pref_c;

    assign d_w        = SW'(d_reg);
    assign pref_w     = SW'(pref_reg);
    assign n_w        = SW'(n_reg);
    assign left_ok    = (d_w <= pref_w);
    assign right_ok   = ((pref_w + d_w) < n_w);
    assign left_addr  = IW'(pref_w - d_w);
    assign right_addr = IW'(pref_w + d_w);
    assign map_hit    = pend_reg && !rd_data_reg;

    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        pref_next        = pref_reg;
        d_next           = d_reg;
        side_next        = side_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        cnt_next         = cnt_reg;
        res_granted_next = res_granted_reg;
        res_addr_next    = res_addr_reg;
        out_valid_next   = out_valid_reg && rsp_stall;
        out_data_next    = out_data_reg;
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg;
        mem_wdata        = 1'b0;
        mem_re           = 1'b0;
        mem_raddr        = left_addr;

        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = 1'b0;
                cnt_next  = cnt_reg + IW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next         = '0;
                    res_granted_next = 1'b0;
                    state_next       = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    if (req_data.action == ACT_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else if (n_c == '0)
                    begin
                        res_granted_next = 1'b0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        n_next     = NW'(n_c);
                        pref_next  = IW'(clamp_c);
                        d_next     = '0;
                        side_next  = SIDE_LEFT;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (map_hit)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = pend_addr_reg;
                    mem_wdata        = 1'b1;
                    res_granted_next = 1'b1;
                    res_addr_next    = pend_addr_reg;
                    state_next       = ST_DONE;
                end
                else if (side_reg == SIDE_LEFT)
                begin
                    if (left_ok)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = left_addr;
                        pend_next      = 1'b1;
                        pend_addr_next = left_addr;
                        if (d_reg == '0)
                        begin
                            d_next = d_reg + NW'(1);
                        end
                        else
                        begin
                            side_next = SIDE_RIGHT;
                        end
                    end
                    else if (right_ok)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = right_addr;
                        pend_next      = 1'b1;
                        pend_addr_next = right_addr;
                        d_next         = d_reg + NW'(1);
                    end
                    else
                    begin
                        res_granted_next = 1'b0;
                        state_next       = ST_DONE;
                    end
                end
                else
                begin
                    if (right_ok)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = right_addr;
                        pend_next      = 1'b1;
                        pend_addr_next = right_addr;
                    end
                    d_next    = d_reg + NW'(1);
                    side_next = SIDE_LEFT;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_data_next.granted = res_granted_reg;
                    out_data_next.slot    = res_granted_reg ? SLOT_W'(res_addr_reg) : '0;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= ACTIVE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        pref_reg        <= pref_next;
        d_reg           <= d_next;
        side_reg        <= side_next;
        pend_addr_reg   <= pend_addr_next;
        res_granted_reg <= res_granted_next;
        res_addr_reg    <= res_addr_next;
        out_data_reg    <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    `NFSA_ASSERT_NXT(a_free_hit_grants, (state_reg == ST_SEARCH) && map_hit, res_granted_reg)
    `NFSA_ASSERT_IMP(a_in_range, (state_reg == ST_DONE) && res_granted_reg, NW'(res_addr_reg) < n_reg)
    `NFSA_ASSERT_IMP(a_dist_bounded, state_reg == ST_SEARCH, d_reg <= n_reg)

endmodule
